@@ hdl/shortest_common_supersequence_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared checks for the supersequence engine.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_COMMON_SUPERSEQUENCE_TOP_MACROS_SVH
`define SHORTEST_COMMON_SUPERSEQUENCE_TOP_MACROS_SVH

// same-cycle implication
`define SCS_ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("implication failed");

// next-cycle implication
`define SCS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle implication failed");

`endif

@@ hdl/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg
// Types and constants of the shortest common supersequence engine.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int MAX_LEN_DEF = 32;

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_TR_INIT,
      ST_TR_RD,
      ST_TR_STEP,
      ST_EM_RD,
      ST_EM_LD,
      ST_EM_EMPTY
   } state_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic start;
      logic fill_rd;
      logic fill_wr;
      logic tr_init;
      logic tr_rd;
      logic tr_step;
      logic em_rd;
      logic em_ld;
      logic em_empty;
   } cmd_type;

   typedef struct packed {
      logic both_empty;
      logic one_empty;
      logic fill_col_end;
      logic fill_row_end;
      logic trace_done;
      logic out_free;
      logic em_last;
   } status_type;

endpackage

@@ hdl/scs_ctrl.sv @@
// ----------------------------------------------------------------------------
// scs_ctrl
// Sequencer for loading, table fill, traceback and emission.
// ----------------------------------------------------------------------------
module scs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  scs_pkg::status_type status,
   output scs_pkg::cmd_type    cmd
);
   import scs_pkg::*;

   state_type state_ff, state_in;
   logic      acc;

   assign acc       = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && (req_opcode == OP_COMPUTE)) begin
               priority if (status.both_empty) state_in = ST_EM_EMPTY;
               else if (status.one_empty)      state_in = ST_TR_INIT;
               else                            state_in = ST_FILL_RD;
            end
         end
         ST_FILL_RD: state_in = ST_FILL_WR;
         ST_FILL_WR: begin
            priority if (status.fill_col_end && status.fill_row_end) state_in = ST_TR_INIT;
            else                                                      state_in = ST_FILL_RD;
         end
         ST_TR_INIT: state_in = ST_TR_RD;
         ST_TR_RD: begin
            if (status.trace_done) state_in = ST_EM_RD;
            else                   state_in = ST_TR_STEP;
         end
         ST_TR_STEP: state_in = ST_TR_RD;
         ST_EM_RD:   state_in = ST_EM_LD;
         ST_EM_LD: begin
            if (status.out_free) state_in = status.em_last ? ST_IDLE : ST_EM_RD;
         end
         ST_EM_EMPTY: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_a = acc && (req_opcode == OP_LOAD_A);
            cmd.load_b = acc && (req_opcode == OP_LOAD_B);
            cmd.start  = acc && (req_opcode == OP_COMPUTE);
         end
         ST_FILL_RD:  cmd.fill_rd  = 1'b1;
         ST_FILL_WR:  cmd.fill_wr  = 1'b1;
         ST_TR_INIT:  cmd.tr_init  = 1'b1;
         ST_TR_RD:    cmd.tr_rd    = 1'b1;
         ST_TR_STEP:  cmd.tr_step  = 1'b1;
         ST_EM_RD:    cmd.em_rd    = 1'b1;
         ST_EM_LD:    cmd.em_ld    = status.out_free;
         ST_EM_EMPTY: cmd.em_empty = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ hdl/scs_dp.sv @@
// ----------------------------------------------------------------------------
// scs_dp
// String stores, LCS table memory, trace buffer and output register.
// ----------------------------------------------------------------------------
module scs_dp #(
   parameter int MAX_LEN = scs_pkg::MAX_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_char_in,
   input  scs_pkg::cmd_type    cmd,
   output scs_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_char_out,
   output logic                rsp_last,
   output logic                rsp_empty_res,
   output logic                rsp_truncated
);
   import scs_pkg::*;

   localparam int LW   = $clog2(MAX_LEN + 1);
   localparam int SW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DIM  = MAX_LEN + 1;
   localparam int TAW  = $clog2(DIM * DIM);
   localparam int TLW  = $clog2(2 * MAX_LEN + 1);
   localparam int TBW  = $clog2(2 * MAX_LEN);

   logic [7:0]     str_a [MAX_LEN];
   logic [7:0]     str_b [MAX_LEN];
   logic [LW-1:0]  tbl   [DIM * DIM];
   logic [7:0]     tbuf  [2 * MAX_LEN];

   logic [LW-1:0]  len_a_ff, len_b_ff, n_ff, m_ff, i_ff, j_ff, left_ff;
   logic           ovf_ff, trn_ff;
   logic [TLW-1:0] tlen_ff, k_ff;
   logic [LW-1:0]  qa_ff, qb_ff;
   logic [7:0]     tq_ff;
   logic           rsp_valid_ff, rsp_last_ff, rsp_empty_ff, rsp_trn_ff;
   logic [7:0]     rsp_char_ff;

   logic [TAW-1:0] ra, rb, wa;
   logic [LW-1:0]  im1, jm1, up, diag, lf, v;
   logic [7:0]     ca, cb, tch;
   logic           match;
   logic [TBW-1:0] trd;

   function automatic logic [TAW-1:0] taddr(input logic [LW-1:0] r, input logic [LW-1:0] c);
      taddr = TAW'(TAW'(r) * TAW'(DIM) + TAW'(c));
   endfunction

   assign im1   = i_ff - LW'(1);
   assign jm1   = j_ff - LW'(1);
   assign ca    = str_a[im1[SW-1:0]];
   assign cb    = str_b[jm1[SW-1:0]];
   assign match = (ca == cb);
   assign trd   = TBW'(tlen_ff - TLW'(1) - k_ff);

   always_comb begin
      ra = taddr(im1, j_ff);
      rb = cmd.tr_rd ? taddr(i_ff, jm1) : taddr(im1, jm1);
      wa = taddr(i_ff, j_ff);
      up   = (i_ff == LW'(1)) ? '0 : qa_ff;
      diag = ((i_ff == LW'(1)) || (j_ff == LW'(1))) ? '0 : qb_ff;
      lf   = (j_ff == LW'(1)) ? '0 : qb_ff;
      v    = match ? LW'(diag + LW'(1)) : ((up > left_ff) ? up : left_ff);
   end

   always_comb begin
      priority if ((i_ff != '0) && (j_ff != '0)) begin
         if (match || (up > lf)) tch = ca;
         else                    tch = cb;
      end else if (i_ff != '0) begin
         tch = ca;
      end else begin
         tch = cb;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_a && (len_a_ff < LW'(MAX_LEN))) str_a[len_a_ff[SW-1:0]] <= req_char_in;
      if (cmd.load_b && (len_b_ff < LW'(MAX_LEN))) str_b[len_b_ff[SW-1:0]] <= req_char_in;
      if (cmd.fill_wr) tbl[wa] <= v;
      qa_ff <= tbl[ra];
      qb_ff <= tbl[rb];
      if (cmd.tr_step) tbuf[tlen_ff[TBW-1:0]] <= tch;
      tq_ff <= tbuf[trd];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff <= '0;
         len_b_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.start) begin
         len_a_ff <= '0;
         len_b_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (cmd.load_a) begin
            if (len_a_ff < LW'(MAX_LEN)) len_a_ff <= len_a_ff + LW'(1);
            else                         ovf_ff   <= 1'b1;
         end
         if (cmd.load_b) begin
            if (len_b_ff < LW'(MAX_LEN)) len_b_ff <= len_b_ff + LW'(1);
            else                         ovf_ff   <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         n_ff    <= len_a_ff;
         m_ff    <= len_b_ff;
         trn_ff  <= ovf_ff;
         i_ff    <= LW'(1);
         j_ff    <= LW'(1);
         left_ff <= '0;
         tlen_ff <= '0;
         k_ff    <= '0;
      end else if (cmd.fill_wr) begin
         if (j_ff == m_ff) begin
            i_ff    <= i_ff + LW'(1);
            j_ff    <= LW'(1);
            left_ff <= '0;
         end else begin
            j_ff    <= j_ff + LW'(1);
            left_ff <= v;
         end
      end else if (cmd.tr_init) begin
         i_ff <= n_ff;
         j_ff <= m_ff;
      end else if (cmd.tr_step) begin
         tlen_ff <= tlen_ff + TLW'(1);
         priority if ((i_ff != '0) && (j_ff != '0)) begin
            if (match) begin
               i_ff <= im1;
               j_ff <= jm1;
            end else if (up > lf) begin
               i_ff <= im1;
            end else begin
               j_ff <= jm1;
            end
         end else if (i_ff != '0) begin
            i_ff <= im1;
         end else begin
            j_ff <= jm1;
         end
      end else if (cmd.em_ld) begin
         k_ff <= k_ff + TLW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.em_ld || cmd.em_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.em_ld) begin
         rsp_char_ff  <= tq_ff;
         rsp_last_ff  <= (k_ff + TLW'(1) == tlen_ff);
         rsp_empty_ff <= 1'b0;
         rsp_trn_ff   <= trn_ff;
      end else if (cmd.em_empty) begin
         rsp_char_ff  <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_empty_ff <= 1'b1;
         rsp_trn_ff   <= trn_ff;
      end
   end

   assign status.both_empty   = (len_a_ff == '0) && (len_b_ff == '0);
   assign status.one_empty    = (len_a_ff == '0) || (len_b_ff == '0);
   assign status.fill_col_end = (j_ff == m_ff);
   assign status.fill_row_end = (i_ff == n_ff);
   assign status.trace_done   = (i_ff == '0) && (j_ff == '0);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.em_last      = (k_ff + TLW'(1) == tlen_ff);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_out  = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_truncated = rsp_trn_ff;

endmodule

@@ hdl/shortest_common_supersequence_top.sv @@
// ----------------------------------------------------------------------------
// shortest_common_supersequence_top
// Shortest common supersequence engine over two byte strings.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: opcode 0 appends req_char_in to the first string, 1 to the
//   second, 2 computes the answer, 3 is ignored. Appends beyond
//   MAX_LEN are dropped and flagged on the next answer.
//   rsp channel: one word per supersequence character in forward order,
//   rsp_last on the final word. Two empty strings give one word with
//   rsp_empty_res set and a zero character.
//   Compute fills the table with a read and a write state per cell, traces
//   back with a read and a step state per step and emits each word with a
//   read and a load state; the load waits while the output register is full.
//   No new word is taken until the last word of an answer is in the
//   output register. A stalled receiver holds the output register and
//   pauses emission. Reset empties both strings and the flag; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
`include "shortest_common_supersequence_top_macros.svh"

module shortest_common_supersequence_top #(
   parameter int MAX_LEN = scs_pkg::MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last,
   output logic       rsp_empty_res,
   output logic       rsp_truncated
);
   import scs_pkg::*;

   cmd_type    cmd;
   status_type status;

   scs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   scs_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_char_in   (req_char_in),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_out  (rsp_char_out),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res),
      .rsp_truncated (rsp_truncated)
   );

   `SCS_ASSERT_IMPLY(a_empty_is_last, clock, reset, rsp_valid && rsp_empty_res, rsp_last)
   `SCS_ASSERT_IMPLY(a_empty_char_zero, clock, reset, rsp_valid && rsp_empty_res, rsp_char_out == 8'd0)
   `SCS_ASSERT_NEXT(a_compute_busy, clock, reset, req_valid && req_ready && (req_opcode == OP_COMPUTE), !req_ready)

endmodule

@@ tb/shortest_common_supersequence_top_tb.sv @@
// ----------------------------------------------------------------------------
// shortest_common_supersequence_top_tb
// Loads pairs of byte strings and computes, checking every answer word
// against a behavioural supersequence predictor, under random idling.
// ----------------------------------------------------------------------------
module shortest_common_supersequence_top_tb;
   import scs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEN = MAX_LEN_DEF;

   typedef struct {
      logic [7:0] ch;
      logic       lst;
      logic       emp;
      logic       trn;
   } answer_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = OP_NONE;
   logic [7:0] req_char_in = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_last;
   logic       rsp_empty_res;
   logic       rsp_truncated;

   logic [7:0] str_a [LEN];
   logic [7:0] str_b [LEN];
   int         len_a, len_b;
   logic       dropped;
   answer_word_type expected_words [$];
   int         mismatches;
   int         unexpected;
   int         hold_off;
   int         burst_left;

   shortest_common_supersequence_top u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void predict_answer();
      logic [5:0] tbl [LEN+1][LEN+1];
      logic [7:0] trace [$];
      answer_word_type w;
      int i, j;
      w.trn = dropped;
      if (len_a == 0 && len_b == 0) begin
         w.ch = 8'd0; w.lst = 1'b1; w.emp = 1'b1;
         expected_words.insert(expected_words.size(), w);
      end else begin
         for (i = 0; i <= len_a; i++)
            for (j = 0; j <= len_b; j++)
               if (i == 0 || j == 0) tbl[i][j] = '0;
               else if (str_a[i-1] == str_b[j-1]) tbl[i][j] = tbl[i-1][j-1] + 6'd1;
               else tbl[i][j] = (tbl[i-1][j] > tbl[i][j-1]) ? tbl[i-1][j] : tbl[i][j-1];
         i = len_a; j = len_b;
         while (i > 0 && j > 0) begin
            if (str_a[i-1] == str_b[j-1]) begin
               trace.push_front(str_a[i-1]); i--; j--;
            end else if (tbl[i-1][j] > tbl[i][j-1]) begin
               trace.push_front(str_a[i-1]); i--;
            end else begin
               trace.push_front(str_b[j-1]); j--;
            end
         end
         while (i > 0) begin trace.push_front(str_a[i-1]); i--; end
         while (j > 0) begin trace.push_front(str_b[j-1]); j--; end
         foreach (trace[k]) begin
            w.ch = trace[k]; w.lst = (k == trace.size() - 1); w.emp = 1'b0;
            expected_words.insert(expected_words.size(), w);
         end
      end
      len_a = 0; len_b = 0; dropped = 1'b0;
   endfunction

   function automatic void predict_item(logic [1:0] op, logic [7:0] ch);
      case (op)
         OP_LOAD_A: begin
            if (len_a < LEN) begin str_a[len_a] = ch; len_a++; end
            else dropped = 1'b1;
         end
         OP_LOAD_B: begin
            if (len_b < LEN) begin str_b[len_b] = ch; len_b++; end
            else dropped = 1'b1;
         end
         OP_COMPUTE: predict_answer();
         default: ;
      endcase
   endfunction

   task automatic send_word(logic [1:0] op, logic [7:0] ch);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_char_in <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(op, ch);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_string(logic [1:0] op, int n, bit narrow);
      for (int k = 0; k < n; k++)
         send_word(op, narrow ? 8'($urandom_range(65, 67)) : 8'($urandom));
   endtask

   task automatic test_directed();
      send_word(OP_COMPUTE, 8'hff);
      send_word(OP_LOAD_A, 8'h00);
      send_word(OP_LOAD_A, 8'hff);
      send_word(OP_NONE, 8'h55);
      send_word(OP_LOAD_B, 8'hff);
      send_word(OP_LOAD_B, 8'h00);
      send_word(OP_LOAD_B, 8'haa);
      send_word(OP_COMPUTE, 8'h00);
      send_word(OP_LOAD_B, 8'h5a);
      send_word(OP_COMPUTE, 8'h00);
      send_word(OP_LOAD_A, 8'ha5);
      send_word(OP_COMPUTE, 8'h00);
      send_word(OP_LOAD_A, 8'h11);
      send_word(OP_LOAD_B, 8'h11);
      send_word(OP_COMPUTE, 8'h00);
      drain();
   endtask

   task automatic test_full_strings();
      send_string(OP_LOAD_A, LEN + 2, 1'b1);
      send_string(OP_LOAD_B, LEN + 1, 1'b0);
      send_word(OP_COMPUTE, 8'h00);
      send_word(OP_LOAD_A, 8'h42);
      send_word(OP_COMPUTE, 8'h00);
      drain();
      send_word(OP_LOAD_B, 8'h42);
      send_string(OP_LOAD_B, LEN, 1'b1);
      send_word(OP_COMPUTE, 8'h00);
      send_word(OP_COMPUTE, 8'h00);
      drain();
   endtask

   task automatic test_backpressure();
      hold_off = 600;
      send_string(OP_LOAD_A, 4, 1'b1);
      send_string(OP_LOAD_B, 4, 1'b1);
      send_word(OP_COMPUTE, 8'h00);
      send_string(OP_LOAD_A, 3, 1'b1);
      send_word(OP_COMPUTE, 8'h00);
      send_string(OP_LOAD_B, 2, 1'b0);
      send_word(OP_COMPUTE, 8'h00);
      drain();
   endtask

   task automatic test_random();
      int op;
      for (int n = 0; n < 12; n++) begin
         bit narrow;
         narrow = $urandom_range(0, 2) != 0;
         send_string(OP_LOAD_A, $urandom_range(0, 6), narrow);
         send_string(OP_LOAD_B, $urandom_range(0, 6), narrow);
         if ($urandom_range(0, 5) == 0) begin
            op = $urandom_range(0, 3);
            send_word(2'(op), 8'($urandom));
         end
         send_word(OP_COMPUTE, 8'($urandom));
         if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
      end
   end

   always @(posedge clock) begin
      answer_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("unexpected word: char %02h last %b", rsp_char_out, rsp_last);
         end else begin
            w = expected_words.pop_front();
            if (rsp_char_out !== w.ch || rsp_last !== w.lst ||
                rsp_empty_res !== w.emp || rsp_truncated !== w.trn) begin
               mismatches++;
               if (mismatches + unexpected <= 10)
                  $display("mismatch: exp %02h/%b/%b/%b got %02h/%b/%b/%b",
                           w.ch, w.lst, w.emp, w.trn, rsp_char_out, rsp_last,
                           rsp_empty_res, rsp_truncated);
            end
         end
      end
   end

   initial begin
      len_a = 0; len_b = 0; dropped = 1'b0;
      mismatches = 0; unexpected = 0; hold_off = 0; burst_left = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_strings();
      test_backpressure();
      test_random();
      if (mismatches == 0 && unexpected == 0 && expected_words.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #30ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
